[hdl/sas_pkg.sv]
// Shared types and constants for the sprite animation sequencer.
package sas_pkg;

    localparam int NUM_PLAYERS = 16;
    localparam int NUM_ANIMS   = 64;
    localparam int MAX_FRAMES  = 32;
    localparam int TIME_BITS   = 16;

    localparam int PLAYER_W = 4;
    localparam int ANIM_W   = 6;
    localparam int FRAME_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int IN_TIME_W = 16;
    localparam int ACC_W    = TIME_BITS + 8;
    localparam int DLY_IDX_W = ANIM_W + FRAME_W;
    localparam int DLY_DEPTH = NUM_ANIMS * MAX_FRAMES;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_IDX_W = 1;

    typedef enum logic [3:0] {
        REQ_TICK         = 4'd0,
        REQ_PLAY         = 4'd1,
        REQ_PLAY_RESTART = 4'd2,
        REQ_PAUSE        = 4'd3,
        REQ_RESUME       = 4'd4,
        REQ_SET_REVERSE  = 4'd5,
        REQ_SET_FRAME    = 4'd6,
        REQ_LOAD_COUNT   = 4'd7,
        REQ_LOAD_DELAY   = 4'd8
    } t_req;

    // Classified command travelling from the front to the back part.
    typedef struct packed {
        logic [3:0]           req;
        logic                 player_ok;
        logic                 anim_ok;
        logic                 frame_ok;
        logic [PLAYER_W-1:0]  player;
        logic [ANIM_W-1:0]    anim;
        logic [FRAME_W-1:0]   frame;
        logic                 loop_flag;
        logic                 reverse_flag;
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS-1:0] delay;
        logic [COUNT_W-1:0]   count;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

endpackage

[hdl/sas_ram.sv]
// Generic single-port-write, registered-read RAM.
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/sas_front.sv]
// Front part: accept beats, classify them and push them into a short queue.
module sas_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [3:0]                     i_req_type,
    input  logic [sas_pkg::PLAYER_W-1:0]   i_player,
    input  logic [sas_pkg::ANIM_W-1:0]     i_anim,
    input  logic [sas_pkg::FRAME_W-1:0]    i_frame,
    input  logic                           i_loop_flag,
    input  logic                           i_reverse_flag,
    input  logic [sas_pkg::IN_TIME_W-1:0]  i_elapsed,
    input  logic [sas_pkg::IN_TIME_W-1:0]  i_delay,
    input  logic [sas_pkg::COUNT_W-1:0]    i_frame_count,
    output logic                           o_cmd_valid,
    output sas_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_pop
);
    sas_pkg::t_cmd r_q [sas_pkg::FIFO_DEPTH];
    logic [sas_pkg::FIFO_IDX_W-1:0] r_wp, r_rp;
    logic [sas_pkg::FIFO_IDX_W:0]   r_cnt;
    sas_pkg::t_cmd w_cmd;
    logic w_push;

    always_comb begin
        w_cmd.req          = i_req_type;
        w_cmd.player_ok    = ({28'd0, i_player} < 32'(sas_pkg::NUM_PLAYERS));
        w_cmd.anim_ok      = ({26'd0, i_anim} < 32'(sas_pkg::NUM_ANIMS));
        w_cmd.frame_ok     = ({27'd0, i_frame} < 32'(sas_pkg::MAX_FRAMES));
        w_cmd.player       = i_player;
        w_cmd.anim         = i_anim;
        w_cmd.frame        = i_frame;
        w_cmd.loop_flag    = i_loop_flag;
        w_cmd.reverse_flag = i_reverse_flag;
        w_cmd.elapsed      = i_elapsed[sas_pkg::TIME_BITS-1:0];
        w_cmd.delay        = i_delay[sas_pkg::TIME_BITS-1:0];
        // Saturate the frame count.
        if ({26'd0, i_frame_count} > 32'(sas_pkg::MAX_FRAMES)) begin
            w_cmd.count = sas_pkg::COUNT_W'(sas_pkg::MAX_FRAMES);
        end else begin
            w_cmd.count = i_frame_count;
        end
    end

    assign o_stall     = (r_cnt == (sas_pkg::FIFO_IDX_W+1)'(sas_pkg::FIFO_DEPTH));
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (sas_pkg::FIFO_IDX_W+1)'(w_push)
                           - (sas_pkg::FIFO_IDX_W+1)'(i_cmd_pop);
        end
    end
endmodule

[hdl/sas_back.sv]
// Back part: read-modify-write of player state and table access.
module sas_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  sas_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sas_pkg::PLAYER_W-1:0]  o_player_out,
    output logic                          o_has_anim,
    output logic                          o_playing,
    output logic [sas_pkg::FRAME_W-1:0]   o_current_frame,
    output logic                          o_looping,
    output logic                          o_reversed,
    output logic                          o_frame_changed
);
    localparam int NP = sas_pkg::NUM_PLAYERS;
    localparam int NA = sas_pkg::NUM_ANIMS;
    localparam int TIME_W_D = sas_pkg::TIME_BITS;

    sas_pkg::t_state r_state, n_state;

    logic [sas_pkg::ANIM_W-1:0]  r_p_anim  [NP];
    logic [NP-1:0]               r_p_has, r_p_play, r_p_loop, r_p_rev;
    logic [sas_pkg::FRAME_W-1:0] r_p_frame [NP];
    logic [sas_pkg::ACC_W-1:0]   r_p_time  [NP];
    // Set once an animation's frame count has been loaded; unloaded counts read as zero.
    logic [NA-1:0]               r_cnt_vld;

    sas_pkg::t_cmd r_cmd;
    logic [TIME_W_D-1:0] w_dly;
    logic [sas_pkg::COUNT_W-1:0] w_cnt_rd;
    logic [sas_pkg::DLY_IDX_W-1:0] w_waddr, w_tick_addr;
    logic w_we, w_cnt_we;

    // Per-player working values for the latched command.
    logic [sas_pkg::ANIM_W-1:0]  w_anim;
    logic [sas_pkg::FRAME_W-1:0] w_f, n_f;
    logic [sas_pkg::ACC_W-1:0]   n_t;
    logic [sas_pkg::ACC_W:0]     w_sum;
    logic [sas_pkg::COUNT_W-1:0] w_cnt;
    logic w_has, n_has, n_play, n_loop, n_rev;
    logic [sas_pkg::ANIM_W-1:0]  n_anim;
    logic w_pw;

    assign w_waddr = {i_cmd.anim, i_cmd.frame};
    assign w_we    = o_cmd_pop && i_cmd.req == sas_pkg::REQ_LOAD_DELAY
                     && i_cmd.player_ok && i_cmd.anim_ok && i_cmd.frame_ok;
    assign w_cnt_we = w_pw && r_cmd.req == sas_pkg::REQ_LOAD_COUNT && r_cmd.anim_ok;

    // A tick reads the delay of the player's current frame.
    assign w_tick_addr = {r_p_anim[i_cmd.player], r_p_frame[i_cmd.player]};

    sas_ram #(.WIDTH(sas_pkg::TIME_BITS), .DEPTH(sas_pkg::DLY_DEPTH)) u_dly (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.delay),
        .i_raddr (w_tick_addr),
        .o_rdata (w_dly)
    );

    // Frame count of the player's animation, read alongside the delay.
    sas_ram #(.WIDTH(sas_pkg::COUNT_W), .DEPTH(sas_pkg::NUM_ANIMS)) u_cnt (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_cmd.anim),
        .i_wdata (r_cmd.count),
        .i_raddr (r_p_anim[i_cmd.player]),
        .o_rdata (w_cnt_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sas_pkg::ST_IDLE: if (i_cmd_valid) n_state = sas_pkg::ST_EXEC;
            sas_pkg::ST_EXEC: n_state = sas_pkg::ST_OUT;
            sas_pkg::ST_OUT:  if (!i_stall) n_state = sas_pkg::ST_IDLE;
            default:          n_state = sas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == sas_pkg::ST_IDLE) && i_cmd_valid;
        w_pw      = (r_state == sas_pkg::ST_EXEC) && r_cmd.player_ok;
    end

    always_comb begin
        w_anim = r_p_anim[r_cmd.player];
        w_f    = r_p_frame[r_cmd.player];
        w_has  = r_p_has[r_cmd.player];
        w_cnt  = r_cnt_vld[w_anim] ? w_cnt_rd : '0;
        n_anim = w_anim;
        n_has  = w_has;
        n_play = r_p_play[r_cmd.player];
        n_loop = r_p_loop[r_cmd.player];
        n_rev  = r_p_rev[r_cmd.player];
        n_f    = w_f;
        n_t    = r_p_time[r_cmd.player];
        w_sum  = {1'b0, n_t} + (sas_pkg::ACC_W+1)'(r_cmd.elapsed);
        case (r_cmd.req) inside
            sas_pkg::REQ_TICK: begin
                if (n_play && w_has && w_cnt != '0) begin
                    // Saturate the accumulator.
                    if (w_sum[sas_pkg::ACC_W]) n_t = '1;
                    else n_t = w_sum[sas_pkg::ACC_W-1:0];
                    if (n_t >= sas_pkg::ACC_W'(w_dly)) begin
                        n_t = n_t - sas_pkg::ACC_W'(w_dly);
                        if (!n_rev) begin
                            if ({1'b0, w_f} + 6'd1 < w_cnt) n_f = w_f + 1'b1;
                            else if (n_loop) n_f = '0;
                            else n_play = 1'b0;
                        end else begin
                            if (w_f != '0) n_f = w_f - 1'b1;
                            else if (n_loop) n_f = sas_pkg::FRAME_W'(w_cnt - 1'b1);
                            else n_play = 1'b0;
                        end
                    end
                end
            end
            sas_pkg::REQ_PLAY, sas_pkg::REQ_PLAY_RESTART: begin
                if (r_cmd.anim_ok) begin
                    if (r_cmd.req == sas_pkg::REQ_PLAY && w_has && w_anim == r_cmd.anim) begin
                        n_play = 1'b1;
                    end else begin
                        n_anim = r_cmd.anim;
                        n_has  = 1'b1;
                        n_f    = '0;
                        n_t    = '0;
                        n_loop = r_cmd.loop_flag;
                        n_play = 1'b1;
                    end
                end
            end
            sas_pkg::REQ_PAUSE:       n_play = 1'b0;
            sas_pkg::REQ_RESUME:      n_play = 1'b1;
            sas_pkg::REQ_SET_REVERSE: n_rev  = r_cmd.reverse_flag;
            sas_pkg::REQ_SET_FRAME: begin
                if (w_has && {1'b0, r_cmd.frame} < w_cnt) begin
                    n_f = r_cmd.frame;
                    n_t = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == sas_pkg::ST_EXEC) begin
            o_player_out    <= r_cmd.player;
            o_has_anim      <= r_cmd.player_ok && n_has;
            o_playing       <= r_cmd.player_ok && n_play;
            o_current_frame <= r_cmd.player_ok ? n_f : '0;
            o_looping       <= r_cmd.player_ok && n_loop;
            o_reversed      <= r_cmd.player_ok && n_rev;
            o_frame_changed <= r_cmd.player_ok && (n_f != w_f);
        end
        if (!i_rst_n) begin
            r_state   <= sas_pkg::ST_IDLE;
            r_p_has   <= '0;
            r_p_play  <= '0;
            r_p_loop  <= '1;
            r_p_rev   <= '0;
            r_cnt_vld <= '0;
            for (int i = 0; i < NP; i++) begin
                r_p_anim[i]  <= '0;
                r_p_frame[i] <= '0;
                r_p_time[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_pw) begin
                r_p_anim[r_cmd.player]  <= n_anim;
                r_p_frame[r_cmd.player] <= n_f;
                r_p_time[r_cmd.player]  <= n_t;
                r_p_has[r_cmd.player]   <= n_has;
                r_p_play[r_cmd.player]  <= n_play;
                r_p_loop[r_cmd.player]  <= n_loop;
                r_p_rev[r_cmd.player]   <= n_rev;
            end
            if (w_cnt_we) begin
                r_cnt_vld[r_cmd.anim] <= 1'b1;
            end
        end
    end

    assign o_valid = (r_state == sas_pkg::ST_OUT);
endmodule

[hdl/sprite_animation_sequencer_top.sv]
// Top level of the sprite animation sequencer.
// Every accepted beat yields exactly one status beat for the addressed
// player. A front stage classifies requests into a two-entry queue; the
// back stage pops one and issues the registered reads of the frame delay
// RAM and the frame count RAM in that cycle, spends the next cycle updating
// player state and registering the result, and then presents the result
// beat, holding it while stalled. The back stage takes no new item until
// its result beat has left; the player read-modify-write is what requires
// this. The front keeps accepting while the queue has room. Delay entries
// never loaded read as undefined values.
module sprite_animation_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_req_type,
    input  logic [3:0]  i_player,
    input  logic [5:0]  i_anim,
    input  logic [4:0]  i_frame,
    input  logic        i_loop_flag,
    input  logic        i_reverse_flag,
    input  logic [15:0] i_elapsed,
    input  logic [15:0] i_delay,
    input  logic [5:0]  i_frame_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_player_out,
    output logic        o_has_anim,
    output logic        o_playing,
    output logic [4:0]  o_current_frame,
    output logic        o_looping,
    output logic        o_reversed,
    output logic        o_frame_changed
);
    logic          w_cmd_valid, w_cmd_pop;
    sas_pkg::t_cmd w_cmd;

    // Accept and classify.
    sas_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_player, .i_anim,
        .i_frame, .i_loop_flag, .i_reverse_flag, .i_elapsed, .i_delay,
        .i_frame_count,
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Execute against player state and tables.
    sas_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid, .i_stall, .o_player_out, .o_has_anim, .o_playing,
        .o_current_frame, .o_looping, .o_reversed, .o_frame_changed
    );
endmodule

[hdl/sas_checker.sv]
// Port-level checks for the sprite animation sequencer.
module sas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_playing,
    input logic       o_has_anim,
    input logic [4:0] o_current_frame,
    input logic       o_frame_changed
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_current_frame) && $stable(o_playing))
        else $error("result changed under stall");
    // A player without an animation stays on frame zero.
    a_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_anim |-> o_current_frame == '0)
        else $error("frame moved off zero without animation");
    // A moved frame needs an animation.
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_changed |-> o_has_anim)
        else $error("frame moved without animation");
    // Results are never presented back to back.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back results");
endmodule

bind sprite_animation_sequencer_top sas_checker u_chk (.*);
